### hw/rtl/rpp_pkg.sv
package rpp_pkg;

	// Parser phase
	typedef enum logic [3:0] {
		PH_IDLE,
		PH_COUNT,
		PH_DIR,
		PH_HEAD,
		PH_TIME,
		PH_SEMI,
		PH_PEND
	} phase_t;

	// Result kind codes
	typedef enum logic [1:0] {
		KIND_CMD     = 2'd0,
		KIND_VALID   = 2'd1,
		KIND_INVALID = 2'd2
	} kind_t;

	// Roll direction codes
	typedef enum logic [1:0] {
		DIR_CW    = 2'd0,
		DIR_CCW   = 2'd1,
		DIR_SHORT = 2'd2
	} dir_t;

	// Plan text characters
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_TILDE = 8'h7E;

	localparam logic [2:0] HEAD_LAST_POS = 3'd2;
	localparam logic [2:0] TIME_LAST_POS = 3'd3;
	localparam logic [9:0] HEAD_MOD      = 10'd360;
	localparam logic [9:0] HEAD_MOD2     = 10'd720;

	// One result item
	typedef struct packed {
		kind_t       kind;
		logic [7:0]  cmd_index;
		dir_t        direction;
		logic [8:0]  heading_deg;
		logic [13:0] roll_time_ms;
		logic [8:0]  plan_count;
	} result_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic [3:0] digit_val(input logic [7:0] c);
		logic [7:0] d;
		d = c - CH_ZERO;
		return d[3:0];
	endfunction

	// Reduce a three-digit heading (below 1000) modulo 360
	function automatic logic [8:0] head_mod(input logic [9:0] h);
		logic [9:0] r;
		if (h >= HEAD_MOD2) begin
			r = h - HEAD_MOD2;
		end else if (h >= HEAD_MOD) begin
			r = h - HEAD_MOD;
		end else begin
			r = h;
		end
		return r[8:0];
	endfunction

endpackage

### hw/rtl/rpp_text_if.sv
interface rpp_text_if;
	logic       valid;
	logic       ready;
	logic       start_req;
	logic [7:0] char_in;

	modport source (output valid, output start_req, output char_in, input ready);
	modport sink   (input valid, input start_req, input char_in, output ready);
endinterface

### hw/rtl/rpp_report_if.sv
interface rpp_report_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  cmd_index;
	logic [1:0]  direction;
	logic [8:0]  heading_deg;
	logic [13:0] roll_time_ms;
	logic [8:0]  plan_count;

	modport source (
		output valid, output kind, output cmd_index, output direction,
		output heading_deg, output roll_time_ms, output plan_count,
		input ready
	);
	modport sink (
		input valid, input kind, input cmd_index, input direction,
		input heading_deg, input roll_time_ms, input plan_count,
		output ready
	);
endinterface

### hw/rtl/rpp_step.sv
module rpp_step import rpp_pkg::*; #(
	parameter int MAX_COMMANDS = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic       start_req,
	input  logic [7:0] char_in,
	output logic       res_fire,
	output result_t    res
);

	localparam int CW = $clog2(MAX_COMMANDS + 1);
	localparam logic [CW+3:0] MaxCnt = (CW+4)'(MAX_COMMANDS);

	phase_t        phase_q, phase_d;
	logic [CW-1:0] count_q, count_d;
	logic          ovf_q, ovf_d;
	logic [CW-1:0] cmd_q, cmd_d;
	logic [2:0]    pos_q, pos_d;
	dir_t          dir_q, dir_d;
	logic [9:0]    head_q, head_d;
	logic [13:0]   time_q, time_d;

	logic          digit;
	logic [3:0]    dval;
	logic [CW+3:0] cnt_next;
	logic          cnt_over;
	logic [CW:0]   cmd_inc;
	logic          last_cmd;
	logic          dir_ok;
	dir_t          dir_new;
	logic [CW+7:0] idx_ext;
	logic [CW+8:0] cnt_ext;

	// Shared decode of the current character
	always_comb begin
		digit    = is_digit(char_in);
		dval     = digit_val(char_in);
		cnt_next = (CW+4)'(count_q) * (CW+4)'(10) + (CW+4)'(dval);
		cnt_over = cnt_next > MaxCnt;
		cmd_inc  = (CW+1)'(cmd_q) + (CW+1)'(1);
		last_cmd = cmd_inc >= (CW+1)'(count_q);
		dir_ok   = 1'b1;
		dir_new  = DIR_CW;
		unique case (char_in)
			CH_PLUS:  dir_new = DIR_CW;
			CH_MINUS: dir_new = DIR_CCW;
			CH_TILDE: dir_new = DIR_SHORT;
			default:  dir_ok = 1'b0;
		endcase
	end

	// Next phase
	always_comb begin
		phase_d = phase_q;
		if (phase_q == PH_PEND) begin
			phase_d = PH_IDLE;
		end else if (start_req) begin
			phase_d = (char_in == CH_HASH) ? PH_COUNT : PH_IDLE;
		end else begin
			unique case (phase_q)
				PH_COUNT: begin
					if (!digit) begin
						if (char_in == CH_NUL || ovf_q || count_q == '0) begin
							phase_d = PH_IDLE;
						end else begin
							phase_d = PH_DIR;
						end
					end
				end
				PH_DIR:  phase_d = dir_ok ? PH_HEAD : PH_IDLE;
				PH_HEAD: begin
					if (!digit) begin
						phase_d = PH_IDLE;
					end else if (pos_q == HEAD_LAST_POS) begin
						phase_d = PH_TIME;
					end
				end
				PH_TIME: begin
					if (!digit) begin
						phase_d = PH_IDLE;
					end else if (pos_q == TIME_LAST_POS) begin
						phase_d = PH_SEMI;
					end
				end
				PH_SEMI: begin
					if (char_in != CH_SEMI) begin
						phase_d = PH_IDLE;
					end else begin
						phase_d = last_cmd ? PH_PEND : PH_DIR;
					end
				end
				default: phase_d = PH_IDLE;
			endcase
		end
	end

	// Data updates and result
	always_comb begin
		count_d          = count_q;
		ovf_d            = ovf_q;
		cmd_d            = cmd_q;
		pos_d            = pos_q;
		dir_d            = dir_q;
		head_d           = head_q;
		time_d           = time_q;
		res_fire         = 1'b0;
		res.kind         = KIND_CMD;
		res.direction    = DIR_CW;
		res.heading_deg  = '0;
		res.roll_time_ms = '0;
		idx_ext          = '0;
		if (phase_q == PH_PEND) begin
			res_fire = 1'b1;
			res.kind = KIND_VALID;
		end else if (start_req) begin
			count_d = '0;
			ovf_d   = 1'b0;
			cmd_d   = '0;
			pos_d   = '0;
			dir_d   = DIR_CW;
			head_d  = '0;
			time_d  = '0;
			if (char_in != CH_HASH) begin
				res_fire = 1'b1;
				res.kind = KIND_INVALID;
			end
		end else begin
			unique case (phase_q)
				PH_COUNT: begin
					if (digit) begin
						if (cnt_over) begin
							ovf_d   = 1'b1;
							count_d = MaxCnt[CW-1:0];
						end else begin
							count_d = cnt_next[CW-1:0];
						end
					end else if (char_in == CH_NUL || ovf_q) begin
						res_fire = 1'b1;
						res.kind = KIND_INVALID;
					end else if (count_q == '0) begin
						res_fire = 1'b1;
						res.kind = KIND_VALID;
					end
				end
				PH_DIR: begin
					if (dir_ok) begin
						dir_d  = dir_new;
						head_d = '0;
						time_d = '0;
						pos_d  = '0;
					end else begin
						res_fire = 1'b1;
						res.kind = KIND_INVALID;
					end
				end
				PH_HEAD: begin
					if (digit) begin
						head_d = 10'(head_q * 10'd10 + 10'(dval));
						pos_d  = (pos_q == HEAD_LAST_POS) ? 3'd0 : pos_q + 3'd1;
					end else begin
						res_fire = 1'b1;
						res.kind = KIND_INVALID;
					end
				end
				PH_TIME: begin
					if (digit) begin
						time_d = 14'(time_q * 14'd10 + 14'(dval));
						pos_d  = (pos_q == TIME_LAST_POS) ? 3'd0 : pos_q + 3'd1;
					end else begin
						res_fire = 1'b1;
						res.kind = KIND_INVALID;
					end
				end
				PH_SEMI: begin
					res_fire = 1'b1;
					if (char_in == CH_SEMI) begin
						cmd_d            = cmd_inc[CW-1:0];
						idx_ext          = (CW+8)'(cmd_q);
						res.direction    = dir_q;
						res.heading_deg  = head_mod(head_q);
						res.roll_time_ms = time_q;
					end else begin
						res.kind = KIND_INVALID;
					end
				end
				default: ;
			endcase
		end
		res.cmd_index  = idx_ext[7:0];
		cnt_ext        = (CW+9)'(count_d);
		res.plan_count = cnt_ext[8:0];
	end

	// Hold state between characters, advance on each processed character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			count_q <= '0;
			ovf_q   <= 1'b0;
			cmd_q   <= '0;
			pos_q   <= '0;
			dir_q   <= DIR_CW;
			head_q  <= '0;
			time_q  <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			count_q <= count_d;
			ovf_q   <= ovf_d;
			cmd_q   <= cmd_d;
			pos_q   <= pos_d;
			dir_q   <= dir_d;
			head_q  <= head_d;
			time_q  <= time_d;
		end
	end

endmodule

### hw/rtl/roll_plan_text_parser.sv
// Channel  Dir  Payload                                                  Transaction
// text     in   start_req, char_in                                       valid & ready
// report   out  kind, cmd_index, direction, heading_deg, roll_time_ms,   valid & ready
//               plan_count
//
// One character per cycle unless the report stalls: an input register, the parser
// step, a result register. A character's result, if any, is offered from there.
// Reset clears the parser to idle and empties both registers.
// A stalled report holds the result register; text.ready then drops only if the
// input register is also full.
module roll_plan_text_parser import rpp_pkg::*; #(
	parameter int MAX_COMMANDS = 256
) (
	input logic          clk,
	input logic          arst_n,
	rpp_text_if.sink     text,
	rpp_report_if.source report
);

	logic       valid_s1;
	logic       start_s1;
	logic [7:0] char_s1;
	logic       valid_s2;
	result_t    res_s2;
	logic       advance;
	logic       res_fire;
	result_t    res;

	// Move a character out of stage one when the result register is free
	assign advance    = !valid_s2 || report.ready;
	assign text.ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.ready) begin
			valid_s1 <= text.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text.valid && text.ready) begin
			start_s1 <= text.start_req;
			char_s1  <= text.char_in;
		end
	end

	rpp_step #(
		.MAX_COMMANDS(MAX_COMMANDS)
	) u_step (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (valid_s1 && advance),
		.start_req(start_s1),
		.char_in  (char_s1),
		.res_fire (res_fire),
		.res      (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1 && res_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && res_fire) begin
			res_s2 <= res;
		end
	end

	assign report.valid        = valid_s2;
	assign report.kind         = res_s2.kind;
	assign report.cmd_index    = res_s2.cmd_index;
	assign report.direction    = res_s2.direction;
	assign report.heading_deg  = res_s2.heading_deg;
	assign report.roll_time_ms = res_s2.roll_time_ms;
	assign report.plan_count   = res_s2.plan_count;

endmodule
